[src/mph_pkg.sv]
// Shared types, codes and defaults for the min-heap priority queue.
`default_nettype none

package mph_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 2;

    typedef logic signed [KEY_W-1:0] key_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // verdict of the shared compare unit
    typedef struct packed {
        logic move;     // key moves past the compared entry
        logic take_b;   // right child chosen over left
    } cmp_res_t;

endpackage

`default_nettype wire

[src/mph_cmp.sv]
// Shared key compare unit for sift-up and sift-down steps.
`default_nettype none

module mph_cmp
(
    input  wire logic          sift_down,
    input  wire mph_pkg::key_t key,
    input  wire mph_pkg::key_t a,
    input  wire mph_pkg::key_t b,
    input  wire logic          b_valid,
    output mph_pkg::cmp_res_t  res
);

    logic          take_b;
    mph_pkg::key_t cand;
    mph_pkg::key_t lhs;
    mph_pkg::key_t rhs;

    // left child wins a tie
    assign take_b = sift_down && b_valid && (b < a);
    assign cand   = take_b ? b : a;

    // going up: key below parent; going down: smaller child below key
    assign lhs = sift_down ? cand : key;
    assign rhs = sift_down ? key : a;

    assign res.move   = lhs < rhs;
    assign res.take_b = take_b;

endmodule

`default_nettype wire

[src/min_heap_priority_queue.sv]
// Top level of the binary min-heap priority queue.
`default_nettype none

// Binary min-heap of signed 32-bit keys held in a CAPACITY-entry memory with one
// write and two registered read ports. An insert (op 0) appends the key and sifts
// it up; a remove (op 1) returns the root and sifts the last entry down from the
// root. The moving key stays in a register; each heap level has a read step for
// the parent or both children, then a compare step that writes one entry. A sift
// stops as soon as the key settles, and full inserts and empty removes skip it.
// One item is worked on at a time: item_ready is high only while idle, and a
// new item is taken while the previous result still waits on the output register.
// Every item gives one result with the removed key, the new minimum, the count
// and a status (0 ok, 1 insert dropped when full, 2 remove when empty).
module min_heap_priority_queue
#(
    parameter int CAPACITY = mph_pkg::CAPACITY_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic                           op,
    input  wire logic signed [mph_pkg::KEY_W-1:0] value,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic signed [mph_pkg::KEY_W-1:0]    removed_value,
    output logic signed [mph_pkg::KEY_W-1:0]    min_value,
    output logic [mph_pkg::COUNT_W-1:0]         count,
    output logic [mph_pkg::STATUS_W-1:0]        status
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CH_W   = ADDR_W + 2;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_UP_RD   = 7'b0000010,
        S_UP_CMP  = 7'b0000100,
        S_DN_LAST = 7'b0001000,
        S_DN_RD   = 7'b0010000,
        S_DN_CMP  = 7'b0100000,
        S_FIN     = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ADDR_W-1:0]             pos_reg, pos_next;
    mph_pkg::key_t                 key_reg, key_next;
    mph_pkg::key_t                 root_reg, root_next;
    mph_pkg::key_t                 removed_reg, removed_next;
    logic [mph_pkg::STATUS_W-1:0]  status_reg, status_next;

    logic                          result_valid_reg, result_valid_next;
    mph_pkg::key_t                 removed_value_reg, removed_value_next;
    mph_pkg::key_t                 min_value_reg, min_value_next;
    logic [mph_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [mph_pkg::STATUS_W-1:0]  status_out_reg, status_out_next;

    mph_pkg::key_t                 heap_mem [CAPACITY];
    mph_pkg::key_t                 rd_a_reg, rd_b_reg;
    logic                          mem_we;
    logic [ADDR_W-1:0]             waddr;
    mph_pkg::key_t                 wdata;
    logic [ADDR_W-1:0]             raddr_a, raddr_b;

    logic [ADDR_W-1:0]             pos_m1;
    logic [ADDR_W-1:0]             parent;
    logic [CH_W-1:0]               left_idx, right_idx;
    logic                          left_ok, right_ok;
    logic                          full;
    mph_pkg::cmp_res_t             cmp_res;

    assign pos_m1    = pos_reg - ADDR_W'(1);
    assign parent    = pos_m1 >> 1;
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + CH_W'(1);
    assign left_ok   = left_idx < CH_W'(cnt_reg);
    assign right_ok  = right_idx < CH_W'(cnt_reg);
    assign full      = cnt_reg == CNT_W'(CAPACITY);

    mph_cmp u_cmp
    (
        .sift_down (state_reg == S_DN_CMP),
        .key       (key_reg),
        .a         (rd_a_reg),
        .b         (rd_b_reg),
        .b_valid   (right_ok),
        .res       (cmp_res)
    );

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        pos_next           = pos_reg;
        key_next           = key_reg;
        removed_next       = removed_reg;
        status_next        = status_reg;
        result_valid_next  = result_valid_reg && !result_ready;
        removed_value_next = removed_value_reg;
        min_value_next     = min_value_reg;
        count_next         = count_reg;
        status_out_next    = status_out_reg;
        mem_we             = 1'b0;
        waddr              = pos_reg;
        wdata              = key_reg;
        raddr_a            = parent;
        raddr_b            = right_idx[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    removed_next = '0;
                    status_next  = mph_pkg::ST_OK;
                    if (op == mph_pkg::OP_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = mph_pkg::ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            key_next   = value;
                            pos_next   = ADDR_W'(cnt_reg);
                            cnt_next   = cnt_reg + CNT_W'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = mph_pkg::ST_EMPTY;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            // fetch the last entry to refill the root
                            removed_next = root_reg;
                            cnt_next     = cnt_reg - CNT_W'(1);
                            raddr_a      = ADDR_W'(cnt_reg - CNT_W'(1));
                            state_next   = S_DN_LAST;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_res.move)
                begin
                    // pull the parent down into the hole
                    wdata      = rd_a_reg;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_DN_LAST:
            begin
                key_next   = rd_a_reg;
                pos_next   = '0;
                state_next = (cnt_reg == '0) ? S_FIN : S_DN_RD;
            end

            S_DN_RD:
            begin
                raddr_a = left_idx[ADDR_W-1:0];
                if (!left_ok)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_res.move)
                begin
                    // lift the smaller child into the hole
                    wdata      = cmp_res.take_b ? rd_b_reg : rd_a_reg;
                    pos_next   = cmp_res.take_b ? right_idx[ADDR_W-1:0]
                                                : left_idx[ADDR_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                // hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next  = 1'b1;
                    removed_value_next = removed_reg;
                    min_value_next     = (cnt_reg != '0) ? root_reg : '0;
                    count_next         = mph_pkg::COUNT_W'(cnt_reg);
                    status_out_next    = status_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        root_next = (mem_we && waddr == '0) ? wdata : root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            pos_reg           <= '0;
            key_reg           <= '0;
            root_reg          <= '0;
            removed_reg       <= '0;
            status_reg        <= mph_pkg::ST_OK;
            result_valid_reg  <= 1'b0;
            removed_value_reg <= '0;
            min_value_reg     <= '0;
            count_reg         <= '0;
            status_out_reg    <= mph_pkg::ST_OK;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            pos_reg           <= pos_next;
            key_reg           <= key_next;
            root_reg          <= root_next;
            removed_reg       <= removed_next;
            status_reg        <= status_next;
            result_valid_reg  <= result_valid_next;
            removed_value_reg <= removed_value_next;
            min_value_reg     <= min_value_next;
            count_reg         <= count_next;
            status_out_reg    <= status_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[waddr] <= wdata;
        end
        rd_a_reg <= heap_mem[raddr_a];
        rd_b_reg <= heap_mem[raddr_b];
    end

    assign item_ready    = state_reg == S_IDLE;
    assign result_valid  = result_valid_reg;
    assign removed_value = removed_value_reg;
    assign min_value     = min_value_reg;
    assign count         = count_reg;
    assign status        = status_out_reg;

endmodule

`default_nettype wire
